/* src/sac_pkg.sv */
// Shared types and constants for the set-associative LRU write-back cache.
// No dependencies; used by sac_lookup and set_assoc_lru_writeback_cache.
`default_nettype none
package sac_pkg;
    localparam int MAX_WAYS_DEF = 16;
    localparam int MAX_SETS_DEF = 2048;

    localparam int TAG_W   = 30;
    localparam int LINE_W  = 32;
    localparam int ORDER_W = 64;
    localparam int POS_N   = 16;
    localparam int CNT_W   = 32;

    // Position 0 holds the most recent way; way i starts at position i.
    localparam logic [ORDER_W-1:0] ORDER_INIT = 64'hFEDC_BA98_7654_3210;

    localparam logic [1:0] REG_WAYS = 2'd0;
    localparam logic [1:0] REG_BBL  = 2'd1;
    localparam logic [1:0] REG_SIB  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } line_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] way;
        logic       wrote_back;
    } lookup_res_t;
endpackage
`default_nettype wire

/* src/sac_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module sac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* src/sac_lookup.sv */
// Tag compare, victim choice and LRU row update for one set row.
// Depends on sac_pkg.
`default_nettype none
module sac_lookup #(
    parameter int MAX_WAYS = sac_pkg::MAX_WAYS_DEF,
    parameter int ROW_W = sac_pkg::ORDER_W + MAX_WAYS * sac_pkg::LINE_W
) (
    input  wire logic [ROW_W-1:0]         row,
    input  wire logic [4:0]               ways,
    input  wire logic [sac_pkg::TAG_W-1:0] tag,
    input  wire logic                     is_write,
    output logic      [ROW_W-1:0]         row_new,
    output sac_pkg::lookup_res_t          res
);
    sac_pkg::line_t [MAX_WAYS-1:0]        lines;
    logic [sac_pkg::POS_N-1:0][3:0]       order;
    logic [sac_pkg::POS_N-1:0][3:0]       order_new;
    sac_pkg::line_t [MAX_WAYS-1:0]        lines_new;
    logic       hit, found, pos_found, victim_dirty;
    logic [3:0] hit_way, free_way, victim_way, way;
    logic [3:0] pos;

    assign order = row[sac_pkg::ORDER_W-1:0];
    assign lines = row[ROW_W-1:sac_pkg::ORDER_W];

    always_comb
    begin
        hit = 1'b0;
        found = 1'b0;
        hit_way = '0;
        free_way = '0;
        victim_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (5'(w) < ways)
            begin
                if (!hit && lines[w].valid && lines[w].tag == tag)
                begin
                    hit = 1'b1;
                    hit_way = 4'(w);
                end
                if (!found && !lines[w].valid)
                begin
                    found = 1'b1;
                    free_way = 4'(w);
                end
            end
        end
        // least recent active way: the last matching position wins
        for (int p = 0; p < sac_pkg::POS_N; p++)
        begin
            if ({1'b0, order[p]} < ways)
            begin
                victim_way = order[p];
            end
        end
    end

    always_comb
    begin
        way = hit ? hit_way : (found ? free_way : victim_way);
        victim_dirty = 1'b0;
        lines_new = lines;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (4'(w) == way)
            begin
                victim_dirty = lines[w].dirty;
                if (hit)
                begin
                    lines_new[w].dirty = lines[w].dirty | is_write;
                end
                else
                begin
                    lines_new[w].valid = 1'b1;
                    lines_new[w].dirty = is_write;
                    lines_new[w].tag = tag;
                end
            end
        end
    end

    always_comb
    begin
        pos = '0;
        pos_found = 1'b0;
        for (int p = 0; p < sac_pkg::POS_N; p++)
        begin
            if (!pos_found && order[p] == way)
            begin
                pos_found = 1'b1;
                pos = 4'(p);
            end
        end
        order_new = order;
        if (pos_found)
        begin
            for (int p = 0; p < sac_pkg::POS_N; p++)
            begin
                if (p == 0)
                begin
                    order_new[p] = way;
                end
                else if (4'(p) <= pos)
                begin
                    order_new[p] = order[p-1];
                end
            end
        end
    end

    assign row_new = {lines_new, order_new};
    assign res.hit = hit;
    assign res.way = way;
    assign res.wrote_back = !hit && victim_dirty;
endmodule
`default_nettype wire

/* src/set_assoc_lru_writeback_cache.sv */
// Tag-only set-associative write-back, write-allocate cache with true LRU. Each
// access reads its set row (tags, state, recency order) from the row RAM, then
// compares, updates and writes the row back, waiting while out_stall holds the last
// result; it takes no new access until that write. After reset the block clears all
// MAX_SETS rows before the first access. Depends on sac_pkg, sac_ram and sac_lookup.
`default_nettype none
module set_assoc_lru_writeback_cache #(
    parameter int MAX_WAYS = sac_pkg::MAX_WAYS_DEF,
    parameter int MAX_SETS = sac_pkg::MAX_SETS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [31:0] byte_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [3:0]       way_used,
    output logic             wrote_back,
    output logic [31:0]      read_count,
    output logic [31:0]      write_count,
    output logic [31:0]      writeback_count,
    output logic [31:0]      read_hit_count,
    output logic [31:0]      write_hit_count,
    output logic [31:0]      read_miss_count,
    output logic [31:0]      write_miss_count
);
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ROW_W = sac_pkg::ORDER_W + MAX_WAYS * sac_pkg::LINE_W;
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [4:0]       ways_reg;
    logic [2:0]       bbl_reg;
    logic [3:0]       sib_reg;
    logic [4:0]       ways_eff;
    logic [2:0]       bbl_eff;
    logic [3:0]       sib_eff;
    logic             func_reg;
    logic [sac_pkg::TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] set_reg;
    logic [31:0]      set_full;
    logic [31:0]      addr_masked;
    logic             in_xfer, out_xfer, commit;
    logic             out_valid_reg, hit_reg, wb_reg;
    logic [3:0]       way_reg;
    logic [31:0]      cnt_reg [7];
    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata, row_new, clear_row;
    sac_pkg::lookup_res_t res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        ways_eff = (ways_reg == 5'd0) ? 5'd1 :
                   ({27'd0, ways_reg} > MAX_WAYS) ? 5'(MAX_WAYS) : ways_reg;
        bbl_eff = (bbl_reg < 3'd2) ? 3'd2 : (bbl_reg > 3'd5) ? 3'd5 : bbl_reg;
        sib_eff = (sib_reg > 4'd11) ? 4'd11 : sib_reg;
        addr_masked = byte_address & ~((32'd1 << bbl_eff) - 32'd1);
        set_full = (byte_address >> bbl_eff) & ((32'd1 << sib_eff) - 32'd1);
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign commit = (state_reg == ST_LOOK) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            ways_reg <= 5'd1;
            bbl_reg <= 3'd2;
            sib_reg <= 4'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 7; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sac_pkg::REG_WAYS: ways_reg <= cfg_data;
                    sac_pkg::REG_BBL:  bbl_reg <= cfg_data[2:0];
                    sac_pkg::REG_SIB:  sib_reg <= cfg_data[3:0];
                    default:           ;
                endcase
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                if (res.wrote_back)
                begin
                    cnt_reg[2] <= cnt_reg[2] + 32'd1;
                end
                if (func_reg)
                begin
                    cnt_reg[1] <= cnt_reg[1] + 32'd1;
                    if (res.hit)
                    begin
                        cnt_reg[4] <= cnt_reg[4] + 32'd1;
                    end
                    else
                    begin
                        cnt_reg[6] <= cnt_reg[6] + 32'd1;
                    end
                end
                else
                begin
                    cnt_reg[0] <= cnt_reg[0] + 32'd1;
                    if (res.hit)
                    begin
                        cnt_reg[3] <= cnt_reg[3] + 32'd1;
                    end
                    else
                    begin
                        cnt_reg[5] <= cnt_reg[5] + 32'd1;
                    end
                end
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func;
            tag_reg <= addr_masked[31:2];
            set_reg <= set_full[SET_W-1:0];
        end
        if (commit)
        begin
            hit_reg <= res.hit;
            way_reg <= res.way;
            wb_reg <= res.wrote_back;
        end
    end

    assign clear_row = {{(ROW_W - sac_pkg::ORDER_W){1'b0}}, sac_pkg::ORDER_INIT};
    assign ram_re = in_xfer;
    assign ram_we = (state_reg == ST_CLEAR) || commit;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? clear_row : row_new;

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (set_full[SET_W-1:0]),
        .rdata (ram_rdata)
    );

    sac_lookup #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lookup (
        .row      (ram_rdata),
        .ways     (ways_eff),
        .tag      (tag_reg),
        .is_write (func_reg),
        .row_new  (row_new),
        .res      (res)
    );

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign way_used = way_reg;
    assign wrote_back = wb_reg;
    assign read_count = cnt_reg[0];
    assign write_count = cnt_reg[1];
    assign writeback_count = cnt_reg[2];
    assign read_hit_count = cnt_reg[3];
    assign write_hit_count = cnt_reg[4];
    assign read_miss_count = cnt_reg[5];
    assign write_miss_count = cnt_reg[6];

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_LOOK)
        else $error("accepted transfer did not enter lookup");
    a_result_from_look: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_LOOK)
        else $error("result raised outside lookup");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("row RAM written while idle");
    a_one_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (cnt_reg[0] + cnt_reg[1]) == ($past(cnt_reg[0] + cnt_reg[1]) + 32'd1))
        else $error("access counters did not advance by one");
endmodule
`default_nettype wire
